// ===== rtl/dtc_pkg.sv =====
// shared constants for the domino tiling counter
`default_nettype none
package dtc_pkg;
	localparam int SIDE_W           = 4;
	localparam int COUNT_W          = 64;
	localparam int RESULT_W         = 63;
	localparam int MAX_SIDE_DEF     = 11;
	localparam int MAX_PATTERNS_DEF = 256;
endpackage
`default_nettype wire

// ===== rtl/dtc_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module dtc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ===== rtl/dtc_pat_check.sv =====
// row pattern check: every run of zero cells in the low w bits has even length
`default_nettype none
module dtc_pat_check
	import dtc_pkg::*;
#(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  wire logic [MAX_SIDE-1:0] bits,
	input  wire logic [SIDE_W-1:0]   w,
	output logic                     ok
);
	// each run is even exactly when the zero count below every one bit, and the total zero count, is even
	always_comb begin
		logic par;
		logic good;
		par  = 1'b0;
		good = 1'b1;
		for (int i = 0; i < MAX_SIDE; i++) begin
			if (SIDE_W'(i) < w) begin
				if (bits[i]) begin
					if (par) begin
						good = 1'b0;
					end
				end else begin
					par = ~par;
				end
			end
		end
		if (par) begin
			good = 1'b0;
		end
		ok = good;
	end
endmodule
`default_nettype wire

// ===== rtl/domino_tiling_count_core.sv =====
// domino tiling counter: sequencer, ping-pong count rams and shared accumulate adder
//
// usage: present side_a and side_b with start high while busy is low; that edge
// accepts the transaction. the result appears on tiling_count, marked by done
// high for exactly one cycle. the receiver cannot stall, so done is never held.
// sides of zero or above MAX_SIDE, and odd board areas, answer with zero in the
// cycle after acceptance without going busy.
// otherwise the wider side w sets the mask width and the other side h the rows.
// the patterns are built and the first row seeded, then each further row clears
// the next count ram and walks every valid pattern p and its submasks, and a
// final read returns the count. the accumulate work comes from the one shared
// 64-bit read-add-write unit, which takes one submask of the current pattern
// per cycle through the count ram ports. one transaction at a time.
// asynchronous reset returns the sequencer to idle; ram contents are rebuilt
// for every transaction, so no clearing pass follows reset.
`default_nettype none
module domino_tiling_count_core
	import dtc_pkg::*;
#(
	parameter int MAX_SIDE     = MAX_SIDE_DEF,
	parameter int MAX_PATTERNS = MAX_PATTERNS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [SIDE_W-1:0]   side_a,
	input  wire logic [SIDE_W-1:0]   side_b,
	output logic                     busy,
	output logic                     done,
	output logic [RESULT_W-1:0]      tiling_count
);
	localparam int AW    = MAX_SIDE;
	localparam int DEPTH = 1 << MAX_SIDE;
	localparam int PIW   = $clog2(MAX_PATTERNS);
	localparam int PTW   = $clog2(MAX_PATTERNS + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_BUILD = 4'd1;
	localparam logic [3:0] S_CLR   = 4'd2;
	localparam logic [3:0] S_PRD   = 4'd3;
	localparam logic [3:0] S_PWAIT = 4'd4;
	localparam logic [3:0] S_RUN   = 4'd5;
	localparam logic [3:0] S_ROWDN = 4'd6;
	localparam logic [3:0] S_FRD   = 4'd7;
	localparam logic [3:0] S_FWAIT = 4'd8;

	logic [3:0]          state_q;
	logic [SIDE_W-1:0]   w_q, h_q, row_q;
	logic [AW-1:0]       span_q, cnt_q, p_q, k_q;
	logic [PTW-1:0]      total_q, j_q;
	logic                sel_q;
	logic                v_s1;
	logic [AW-1:0]       waddr_s1;
	logic                done_q;
	logic [RESULT_W-1:0] count_q;

	logic                side_bad, area_odd;
	logic [SIDE_W-1:0]   w_in, h_in;
	logic                pat_ok;

	logic                prev_we, next_we;
	logic [AW-1:0]       prev_waddr, next_waddr, prev_raddr, next_raddr;
	logic [COUNT_W-1:0]  prev_wdata, next_wdata, prev_rdata, next_rdata;
	logic [COUNT_W-1:0]  r0_rdata, r1_rdata, acc_sum;

	logic                pat_we;
	logic [AW-1:0]       pat_rdata;

	assign side_bad = (side_a == '0) || (side_b == '0) ||
	                  (side_a > SIDE_W'(MAX_SIDE)) || (side_b > SIDE_W'(MAX_SIDE));
	assign w_in     = (side_a > side_b) ? side_a : side_b;
	assign h_in     = (side_a > side_b) ? side_b : side_a;
	assign area_odd = w_in[0] & h_in[0];

	dtc_pat_check #(.MAX_SIDE(MAX_SIDE)) u_check (
		.bits (cnt_q),
		.w    (w_q),
		.ok   (pat_ok)
	);

	assign pat_we = (state_q == S_BUILD) && pat_ok && (total_q < PTW'(MAX_PATTERNS));

	dtc_ram #(.WIDTH(AW), .DEPTH(MAX_PATTERNS)) u_pat_ram (
		.clk   (clk),
		.we    (pat_we),
		.waddr (total_q[PIW-1:0]),
		.wdata (cnt_q),
		.raddr (j_q[PIW-1:0]),
		.rdata (pat_rdata)
	);

	// shared accumulate unit: next[p ^ k] += prev[k]
	assign acc_sum = prev_rdata + next_rdata;

	always_comb begin
		prev_we    = (state_q == S_BUILD);
		prev_waddr = cnt_q;
		// only patterns that made it into the list seed the first row
		prev_wdata = {{(COUNT_W-1){1'b0}}, pat_we};
		prev_raddr = (state_q == S_RUN) ? k_q : '0;
		next_we    = v_s1 || (state_q == S_CLR);
		next_waddr = v_s1 ? waddr_s1 : cnt_q;
		next_wdata = v_s1 ? acc_sum : '0;
		next_raddr = p_q ^ k_q;
	end

	// sel_q picks which ram holds the previous row
	dtc_ram #(.WIDTH(COUNT_W), .DEPTH(DEPTH)) u_cnt_ram0 (
		.clk   (clk),
		.we    (sel_q ? next_we    : prev_we),
		.waddr (sel_q ? next_waddr : prev_waddr),
		.wdata (sel_q ? next_wdata : prev_wdata),
		.raddr (sel_q ? next_raddr : prev_raddr),
		.rdata (r0_rdata)
	);

	dtc_ram #(.WIDTH(COUNT_W), .DEPTH(DEPTH)) u_cnt_ram1 (
		.clk   (clk),
		.we    (sel_q ? prev_we    : next_we),
		.waddr (sel_q ? prev_waddr : next_waddr),
		.wdata (sel_q ? prev_wdata : next_wdata),
		.raddr (sel_q ? prev_raddr : next_raddr),
		.rdata (r1_rdata)
	);

	assign prev_rdata = sel_q ? r1_rdata : r0_rdata;
	assign next_rdata = sel_q ? r0_rdata : r1_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			w_q      <= '0;
			h_q      <= '0;
			row_q    <= '0;
			span_q   <= '0;
			cnt_q    <= '0;
			p_q      <= '0;
			k_q      <= '0;
			total_q  <= '0;
			j_q      <= '0;
			sel_q    <= 1'b0;
			v_s1     <= 1'b0;
			waddr_s1 <= '0;
			done_q   <= 1'b0;
			count_q  <= '0;
		end else begin
			done_q   <= 1'b0;
			v_s1     <= 1'b0;
			waddr_s1 <= p_q ^ k_q;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (side_bad || area_odd) begin
							count_q <= '0;
							done_q  <= 1'b1;
						end else begin
							w_q     <= w_in;
							h_q     <= h_in;
							span_q  <= ~({AW{1'b1}} << w_in);
							cnt_q   <= '0;
							total_q <= '0;
							sel_q   <= 1'b0;
							state_q <= S_BUILD;
						end
					end
				end
				S_BUILD: begin
					if (pat_we) begin
						total_q <= total_q + 1'b1;
					end
					if (cnt_q == span_q) begin
						cnt_q <= '0;
						row_q <= SIDE_W'(1);
						if (h_q == SIDE_W'(1)) begin
							state_q <= S_FRD;
						end else begin
							state_q <= S_CLR;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_CLR: begin
					if (cnt_q == span_q) begin
						cnt_q   <= '0;
						j_q     <= '0;
						state_q <= S_PRD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_PRD: begin
					state_q <= S_PWAIT;
				end
				S_PWAIT: begin
					p_q     <= pat_rdata;
					k_q     <= pat_rdata;
					state_q <= S_RUN;
				end
				S_RUN: begin
					// walk the submasks of p downward, one per cycle
					v_s1 <= 1'b1;
					if (k_q == '0) begin
						if (PTW'(j_q + 1'b1) == total_q) begin
							state_q <= S_ROWDN;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_PRD;
						end
					end else begin
						k_q <= (k_q - 1'b1) & p_q;
					end
				end
				S_ROWDN: begin
					sel_q <= ~sel_q;
					if (row_q == h_q - 1'b1) begin
						state_q <= S_FRD;
					end else begin
						row_q   <= row_q + 1'b1;
						state_q <= S_CLR;
					end
				end
				S_FRD: begin
					state_q <= S_FWAIT;
				end
				S_FWAIT: begin
					count_q <= prev_rdata[RESULT_W-1:0];
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign tiling_count = count_q;
endmodule
`default_nettype wire
